// File: src/oled_shadowed_pixel_writer_assert.svh
// Assertion macros used by the checker file of the pixel writer.
`ifndef OLED_SHADOWED_PIXEL_WRITER_ASSERT_SVH
`define OLED_SHADOWED_PIXEL_WRITER_ASSERT_SVH

// Same-cycle implication, off while reset is held.
`define OSPW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("pixel writer check failed");

// Next-cycle implication, off while reset is held.
`define OSPW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("pixel writer check failed");

// Next-cycle implication that is also checked during reset.
`define OSPW_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("pixel writer check failed");

`endif

// File: src/ospw_pkg.sv
// Package: types, constants and codes of the shadowed pixel writer.
`timescale 1ns / 1ps
package ospw_pkg;

  // Shadow geometry
  localparam int SHADOW_BYTES = 1024;
  localparam int ROW_STRIDE   = 128;
  localparam int ADDR_W       = $clog2(SHADOW_BYTES);
  // widest byte index: last page times stride plus the largest column
  localparam int IDX_W        = $clog2(31 * ROW_STRIDE + 256);

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_PANEL_TYPE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FLIP       = 1'd1;

  // Panel types with offsets
  localparam logic [1:0] PANEL_64X32  = 2'd2;
  localparam logic [1:0] PANEL_132X64 = 2'd3;
  localparam logic [8:0] COL_OFS_64X32  = 9'd32;
  localparam logic [8:0] COL_OFS_132X64 = 9'd2;
  localparam logic [5:0] PAGE_OFS_64X32 = 6'd4;

  // Frame kinds
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_CMD  = 2'd1;
  localparam logic [1:0] KIND_DATA = 2'd2;

  // Status codes
  localparam logic [1:0] ST_WRITTEN = 2'd0;
  localparam logic [1:0] ST_SAME    = 2'd1;
  localparam logic [1:0] ST_OFF     = 2'd2;

  // Panel command bytes
  localparam logic [7:0] CMD_PAGE   = 8'hB0;
  localparam logic [7:0] CMD_COL_LO = 8'h00;
  localparam logic [7:0] CMD_COL_HI = 8'h10;

  typedef struct packed {
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;
    logic       color;
  } in_item_t;

  typedef struct packed {
    logic [1:0] frame_kind;
    logic [7:0] payload;
    logic [1:0] status;
    logic       last;
  } out_item_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CMP,
    S_LOW,
    S_HIGH,
    S_DATA
  } state_t;

  // Which result beat the datapath loads into its output register
  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_OFF,
    EMIT_SAME,
    EMIT_PAGE,
    EMIT_LOW,
    EMIT_HIGH,
    EMIT_DATA
  } emit_t;

  typedef struct packed {
    logic  clr_step;
    logic  accept;
    logic  wr_back;
    emit_t emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic off_screen;
    logic unchanged;
  } dp_status_t;

endpackage

// File: src/oled_shadowed_pixel_writer.sv
// Top level of the shadowed pixel writer for a page-mode monochrome panel.
`timescale 1ns / 1ps
// Usage:
//   Input: drive in_data and raise start; the beat is taken at a clock edge
//   where start is high and busy is low. busy stays high while an item is
//   in work and during the clearing pass after reset.
//   Results: each beat sits on out_data for one cycle with out_valid high;
//   the receiver cannot stall, so it must take every beat as it comes.
//   An off-screen pixel gives one status beat; an unchanged byte gives one
//   status beat; a changed byte gives page, low column, high column and
//   data beats back to back, the last one flagged. A new item is taken only
//   after the controller is back in idle, once the last beat of the previous
//   item is in the result register. The accept is followed by the shadow
//   RAM read, then the compare and write-back (with the page beat), then
//   the frame sequencer gives one beat per cycle.
//   Reset: rst_n low clears config to 128x64 unflipped; afterwards a
//   clearing pass zeroes the 1024-byte shadow one byte per cycle
//   with busy high. Config writes are taken at any time but
//   should be made only while the block is idle.
module oled_shadowed_pixel_writer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  ospw_pkg::in_item_t              in_data,
  output logic                            out_valid,
  output ospw_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [ospw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ospw_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  ospw_pkg::ctrl_cmd_t  cmd;
  ospw_pkg::dp_status_t st;

  ospw_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .busy (busy),
    .st   (st),
    .cmd  (cmd)
  );

  ospw_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .cmd      (cmd),
    .st       (st),
    .out_valid(out_valid),
    .out_data (out_data)
  );

endmodule

// File: src/ospw_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ospw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: src/ospw_ctrl.sv
// Controller: sequences clearing, lookup, compare and the four frame beats.
`timescale 1ns / 1ps
module ospw_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  ospw_pkg::dp_status_t st,
  output ospw_pkg::ctrl_cmd_t  cmd
);

  ospw_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ospw_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ospw_pkg::S_CLEAR: begin
        if (st.clr_done) state_nxt = ospw_pkg::S_IDLE;
      end
      ospw_pkg::S_IDLE: begin
        if (start) state_nxt = ospw_pkg::S_READ;
      end
      ospw_pkg::S_READ: begin
        state_nxt = st.off_screen ? ospw_pkg::S_IDLE : ospw_pkg::S_CMP;
      end
      ospw_pkg::S_CMP: begin
        state_nxt = st.unchanged ? ospw_pkg::S_IDLE : ospw_pkg::S_LOW;
      end
      ospw_pkg::S_LOW:  state_nxt = ospw_pkg::S_HIGH;
      ospw_pkg::S_HIGH: state_nxt = ospw_pkg::S_DATA;
      ospw_pkg::S_DATA: state_nxt = ospw_pkg::S_IDLE;
      default:          state_nxt = ospw_pkg::S_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd.clr_step = 1'b0;
    cmd.accept   = 1'b0;
    cmd.wr_back  = 1'b0;
    cmd.emit     = ospw_pkg::EMIT_NONE;
    busy         = 1'b1;
    case (state_r)
      ospw_pkg::S_CLEAR: cmd.clr_step = 1'b1;
      ospw_pkg::S_IDLE: begin
        busy       = 1'b0;
        cmd.accept = start;
      end
      ospw_pkg::S_READ: begin
        if (st.off_screen) cmd.emit = ospw_pkg::EMIT_OFF;
      end
      ospw_pkg::S_CMP: begin
        if (st.unchanged) begin
          cmd.emit = ospw_pkg::EMIT_SAME;
        end else begin
          cmd.wr_back = 1'b1;
          cmd.emit    = ospw_pkg::EMIT_PAGE;
        end
      end
      ospw_pkg::S_LOW:  cmd.emit = ospw_pkg::EMIT_LOW;
      ospw_pkg::S_HIGH: cmd.emit = ospw_pkg::EMIT_HIGH;
      ospw_pkg::S_DATA: cmd.emit = ospw_pkg::EMIT_DATA;
      default:          cmd.emit = ospw_pkg::EMIT_NONE;
    endcase
  end

endmodule

// File: src/ospw_dp.sv
// Datapath: config registers, shadow RAM, byte update and result register.
`timescale 1ns / 1ps
module ospw_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ospw_pkg::in_item_t                  in_data,
  input  logic                                cfg_we,
  input  logic [ospw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ospw_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  ospw_pkg::ctrl_cmd_t                 cmd,
  output ospw_pkg::dp_status_t                st,
  output logic                                out_valid,
  output ospw_pkg::out_item_t                 out_data
);

  logic [1:0]                    panel_type_r;
  logic                          flip_r;
  logic [7:0]                    x_r;
  logic [2:0]                    bit_r;
  logic [4:0]                    page_r;
  logic                          color_r;
  logic [ospw_pkg::ADDR_W-1:0]   addr_r;
  logic                          off_r;
  logic [7:0]                    newb_r;
  logic [ospw_pkg::ADDR_W-1:0]   clr_cnt_r;
  logic                          out_valid_r;
  ospw_pkg::out_item_t           out_r, out_nxt;

  logic [ospw_pkg::IDX_W-1:0]    idx;
  logic [7:0]                    rdata;
  logic [7:0]                    mask;
  logic [7:0]                    newb;
  logic [8:0]                    col;
  logic [5:0]                    page_ofs;
  logic                          ram_we;
  logic [ospw_pkg::ADDR_W-1:0]   ram_waddr;
  logic [7:0]                    ram_wdata;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      panel_type_r <= 2'd0;
      flip_r       <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        ospw_pkg::REG_PANEL_TYPE: panel_type_r <= cfg_wdata[1:0];
        ospw_pkg::REG_FLIP:       flip_r       <= cfg_wdata[0];
        default:                  flip_r       <= flip_r;
      endcase
    end
  end

  // byte index of the pixel in the shadow
  assign idx = ospw_pkg::IDX_W'(in_data.pixel_y[7:3]) * ospw_pkg::IDX_W'(ospw_pkg::ROW_STRIDE)
             + ospw_pkg::IDX_W'(in_data.pixel_x);

  // latch the accepted beat
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      x_r     <= in_data.pixel_x;
      bit_r   <= in_data.pixel_y[2:0];
      page_r  <= in_data.pixel_y[7:3];
      color_r <= in_data.color;
      addr_r  <= idx[ospw_pkg::ADDR_W-1:0];
      off_r   <= (idx >= ospw_pkg::IDX_W'(ospw_pkg::SHADOW_BYTES));
    end
  end

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt_r <= clr_cnt_r + ospw_pkg::ADDR_W'(1);
    end
  end

  // new byte from the stored one
  assign mask = 8'd1 << bit_r;
  assign newb = color_r ? (rdata | mask) : (rdata & ~mask);

  always_ff @(posedge clk) begin
    if (cmd.wr_back) begin
      newb_r <= newb;
    end
  end

  // shadow RAM: clearing writes zero, update writes the new byte
  assign ram_we    = cmd.clr_step | cmd.wr_back;
  assign ram_waddr = cmd.clr_step ? clr_cnt_r : addr_r;
  assign ram_wdata = cmd.clr_step ? 8'd0 : newb;

  ospw_ram #(
    .WIDTH(8),
    .DEPTH(ospw_pkg::SHADOW_BYTES)
  ) u_shadow (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(addr_r),
    .rdata(rdata)
  );

  assign st.clr_done   = (clr_cnt_r == ospw_pkg::ADDR_W'(ospw_pkg::SHADOW_BYTES - 1));
  assign st.off_screen = off_r;
  assign st.unchanged  = (newb == rdata);

  // panel offsets
  always_comb begin
    col      = {1'b0, x_r};
    page_ofs = {1'b0, page_r};
    if (panel_type_r == ospw_pkg::PANEL_64X32) begin
      col = {1'b0, x_r} + ospw_pkg::COL_OFS_64X32;
      if (!flip_r) page_ofs = {1'b0, page_r} + ospw_pkg::PAGE_OFS_64X32;
    end else if (panel_type_r == ospw_pkg::PANEL_132X64) begin
      col = {1'b0, x_r} + ospw_pkg::COL_OFS_132X64;
    end
  end

  // next result beat
  always_comb begin
    out_nxt.frame_kind = ospw_pkg::KIND_CMD;
    out_nxt.payload    = 8'd0;
    out_nxt.status     = ospw_pkg::ST_WRITTEN;
    out_nxt.last       = 1'b0;
    case (cmd.emit)
      ospw_pkg::EMIT_OFF: begin
        out_nxt.frame_kind = ospw_pkg::KIND_NONE;
        out_nxt.status     = ospw_pkg::ST_OFF;
        out_nxt.last       = 1'b1;
      end
      ospw_pkg::EMIT_SAME: begin
        out_nxt.frame_kind = ospw_pkg::KIND_NONE;
        out_nxt.status     = ospw_pkg::ST_SAME;
        out_nxt.last       = 1'b1;
      end
      ospw_pkg::EMIT_PAGE: out_nxt.payload = ospw_pkg::CMD_PAGE | {2'b00, page_ofs};
      ospw_pkg::EMIT_LOW:  out_nxt.payload = ospw_pkg::CMD_COL_LO | {4'h0, col[3:0]};
      ospw_pkg::EMIT_HIGH: out_nxt.payload = ospw_pkg::CMD_COL_HI | {4'h0, col[7:4]};
      ospw_pkg::EMIT_DATA: begin
        out_nxt.frame_kind = ospw_pkg::KIND_DATA;
        out_nxt.payload    = newb_r;
        out_nxt.last       = 1'b1;
      end
      default: out_nxt.frame_kind = ospw_pkg::KIND_NONE;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.emit != ospw_pkg::EMIT_NONE);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit != ospw_pkg::EMIT_NONE) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: src/ospw_checker.sv
// Port-level checker of the shadowed pixel writer, bound to the top level.
`timescale 1ns / 1ps
`include "oled_shadowed_pixel_writer_assert.svh"
module ospw_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input ospw_pkg::out_item_t out_data
);

  // reset starts the clearing pass, so no item is taken right after it
  `OSPW_ASSERT_NEXT_ALWAYS(a_busy_after_reset, clk, !rst_n, busy)

  // an accepted beat keeps the block busy in the next cycle
  `OSPW_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, start && !busy, busy)

  // the frames of a written byte come back to back up to the last one
  `OSPW_ASSERT_NEXT(a_frames_contiguous, clk, rst_n, out_valid && !out_data.last, out_valid)

  // a beat that carries no frame is a lone status beat
  `OSPW_ASSERT_NOW(a_status_beat_last, clk, rst_n,
    out_valid && (out_data.frame_kind == ospw_pkg::KIND_NONE), out_data.last)

endmodule

bind oled_shadowed_pixel_writer ospw_checker u_ospw_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .out_valid(out_valid),
  .out_data (out_data)
);

// File: tb/sv/oled_shadowed_pixel_writer_tb.sv
`timescale 1ns / 1ps
// Testbench for the shadowed pixel writer: directed and random pixel writes checked against a local shadow image.
module oled_shadowed_pixel_writer_tb;
  import ospw_pkg::*;

  // Panel types that the package leaves unnamed
  localparam logic [1:0] PANEL_128X64 = 2'd0;
  localparam logic [1:0] PANEL_128X32 = 2'd1;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int RAND_PHASES     = 6;
  localparam int ITEMS_PER_PHASE = 52;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  start     = 1'b0;
  in_item_t              in_data   = '0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  busy;
  logic                  out_valid;
  out_item_t             out_data;

  // Predicted shadow image and configuration
  logic [7:0] shadow_img [SHADOW_BYTES];
  logic [1:0] panel_cfg = PANEL_128X64;
  logic       flip_cfg  = 1'b0;

  // Beats still owed by the block, oldest first
  out_item_t frame_q [$];

  int mismatch_cnt = 0;
  int cycle_cnt    = 0;
  int burst_left   = 0;

  always #2 clk = ~clk;

  oled_shadowed_pixel_writer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  function automatic out_item_t make_beat(input logic [1:0] kind, input logic [7:0] payload,
                                          input logic [1:0] status, input logic last);
    out_item_t b;
    b.frame_kind = kind;
    b.payload    = payload;
    b.status     = status;
    b.last       = last;
    return b;
  endfunction

  // Apply one pixel write to the shadow image and queue the beats it yields
  function automatic void predict_pixel(input in_item_t px);
    int         page;
    int         idx;
    int         col;
    logic [7:0] mask;
    logic [7:0] oldb;
    logic [7:0] newb;
    page = int'(px.pixel_y >> 3);
    idx  = page * ROW_STRIDE + int'(px.pixel_x);
    if (idx >= SHADOW_BYTES) begin
      frame_q.push_back(make_beat(KIND_NONE, 8'h00, ST_OFF, 1'b1));
      return;
    end
    mask = 8'h01 << px.pixel_y[2:0];
    oldb = shadow_img[idx];
    newb = px.color ? (oldb | mask) : (oldb & ~mask);
    if (newb == oldb) begin
      frame_q.push_back(make_beat(KIND_NONE, 8'h00, ST_SAME, 1'b1));
      return;
    end
    shadow_img[idx] = newb;
    // offsets by panel type; flip only moves the page of the small panel
    col = int'(px.pixel_x);
    if (panel_cfg == PANEL_64X32) begin
      col = col + int'(COL_OFS_64X32);
      if (!flip_cfg) page = page + int'(PAGE_OFS_64X32);
    end else if (panel_cfg == PANEL_132X64) begin
      col = col + int'(COL_OFS_132X64);
    end
    frame_q.push_back(make_beat(KIND_CMD, CMD_PAGE | 8'(page), ST_WRITTEN, 1'b0));
    frame_q.push_back(make_beat(KIND_CMD, CMD_COL_LO | {4'h0, 4'(col)}, ST_WRITTEN, 1'b0));
    frame_q.push_back(make_beat(KIND_CMD, CMD_COL_HI | {4'h0, 4'(col >> 4)}, ST_WRITTEN, 1'b0));
    frame_q.push_back(make_beat(KIND_DATA, newb, ST_WRITTEN, 1'b1));
  endfunction

  // Send one beat; start stays up inside a burst, drops for a random gap after it
  task automatic send_pixel(input logic [7:0] x, input logic [7:0] y, input logic c);
    in_item_t px;
    px.pixel_x = x;
    px.pixel_y = y;
    px.color   = c;
    start   <= 1'b1;
    in_data <= px;
    do @(posedge clk); while (busy !== 1'b0);
    predict_pixel(px);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  // Stop sending and wait until every owed beat is in and the block is free
  task automatic wait_idle;
    start <= 1'b0;
    do @(posedge clk); while (frame_q.size() != 0 || busy !== 1'b0);
  endtask

  task automatic set_panel(input logic [1:0] ptype, input logic flip);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_PANEL_TYPE;
    cfg_wdata <= ptype;
    @(posedge clk);
    panel_cfg = ptype;
    cfg_index <= REG_FLIP;
    cfg_wdata <= {1'b0, flip};
    @(posedge clk);
    flip_cfg = flip;
    cfg_we   <= 1'b0;
  endtask

  // Set, clear, unchanged, off screen and column aliasing on the plain panel
  task automatic test_basic_writes;
    set_panel(PANEL_128X64, 1'b0);
    send_pixel(8'd0,   8'd0,   1'b1);
    send_pixel(8'd0,   8'd0,   1'b1);
    send_pixel(8'd0,   8'd7,   1'b1);
    send_pixel(8'd0,   8'd0,   1'b0);
    send_pixel(8'd0,   8'd0,   1'b0);
    send_pixel(8'd127, 8'd63,  1'b1);
    send_pixel(8'd128, 8'd63,  1'b1);
    send_pixel(8'd255, 8'd255, 1'b1);
    send_pixel(8'd0,   8'd255, 1'b0);
    // column past the stride lands in the next page's byte
    send_pixel(8'd255, 8'd0,   1'b1);
    send_pixel(8'd127, 8'd8,   1'b0);
    send_pixel(8'd255, 8'd0,   1'b0);
    send_pixel(8'd200, 8'd56,  1'b1);
  endtask

  // Column and page offsets of the 64x32 panel with both flip settings, and of the 132x64 and 128x32 panels
  task automatic test_panel_offsets;
    set_panel(PANEL_64X32, 1'b0);
    send_pixel(8'd95,  8'd56, 1'b1);
    send_pixel(8'd255, 8'd7,  1'b1);
    set_panel(PANEL_64X32, 1'b1);
    send_pixel(8'd10,  8'd10, 1'b1);
    send_pixel(8'd95,  8'd56, 1'b0);
    set_panel(PANEL_132X64, 1'b1);
    send_pixel(8'd129, 8'd0,  1'b1);
    send_pixel(8'd0,   8'd63, 1'b1);
    set_panel(PANEL_128X32, 1'b0);
    send_pixel(8'd5,   8'd31, 1'b1);
  endtask

  // Random pixels over several panel settings
  task automatic test_random_pixels;
    int         sel;
    logic [7:0] x;
    logic [7:0] y;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: set_panel(PANEL_128X64, 1'b0);
        1: set_panel(PANEL_128X32, 1'b1);
        2: set_panel(PANEL_64X32, 1'b0);
        3: set_panel(PANEL_64X32, 1'b1);
        4: set_panel(PANEL_132X64, 1'b0);
        default: set_panel(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        sel = $urandom_range(0, 9);
        if (sel <= 5) begin
          // on screen
          x = 8'($urandom_range(0, 127));
          y = 8'($urandom_range(0, 63));
        end else if (sel <= 7) begin
          // small hot spot, many unchanged bytes
          x = 8'($urandom_range(0, 3));
          y = 8'($urandom_range(0, 15));
        end else if (sel == 8) begin
          x = 8'($urandom_range(0, 255));
          y = 8'($urandom_range(0, 255));
        end else begin
          // column past the stride, partly off screen
          x = 8'($urandom_range(128, 255));
          y = 8'($urandom_range(0, 63));
        end
        send_pixel(x, y, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin : check_beats
    out_item_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (frame_q.size() == 0) begin
        $error("unexpected beat: frame_kind %0d payload %h status %0d last %0d",
               out_data.frame_kind, out_data.payload, out_data.status, out_data.last);
        mismatch_cnt++;
      end else begin
        want = frame_q.pop_front();
        if (out_data.frame_kind !== want.frame_kind) begin
          $error("frame_kind: expected %0d, got %0d", want.frame_kind, out_data.frame_kind);
          mismatch_cnt++;
        end
        if (out_data.payload !== want.payload) begin
          $error("payload: expected %h, got %h", want.payload, out_data.payload);
          mismatch_cnt++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          mismatch_cnt++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_data.last);
          mismatch_cnt++;
        end
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("[oled_shadowed_pixel_writer] ERROR");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < SHADOW_BYTES; i++) shadow_img[i] = 8'h00;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    // let the clearing pass raise busy before looking at it
    @(posedge clk);
    test_basic_writes();
    test_panel_offsets();
    test_random_pixels();
    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0 && frame_q.size() == 0) begin
      $display("[oled_shadowed_pixel_writer] OK");
    end else begin
      $display("[oled_shadowed_pixel_writer] ERROR");
    end
    $finish;
  end

endmodule
